// ===== design/crp_pkg.sv =====
// Shared types, constants and helpers of the Catmull-Rom path evaluator.
package crp_pkg;

	localparam int DEF_MAX_KEYS = 64;
	localparam int FRAC_BITS = 16;
	localparam int DIV_DEN_W = 33;
	localparam int DIV_NUM_W = DIV_DEN_W + FRAC_BITS;
	localparam int LERP_LAST = 8;
	// One bit per de Casteljau step: 1 = lerp the two front points, 0 = drop the front point.
	localparam logic [LERP_LAST:0] LERP_SEQ = 9'b100110111;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_EVAL = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_ZERO_SEG = 2'd2;

	typedef struct packed {
		logic hold;
		logic [2:0][31:0] vel;
		logic [2:0][31:0] pos;
		logic [31:0] tstamp;
	} key_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_INS_WR,
		ST_ONE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_LD_RD,
		ST_LD_CAP,
		ST_DUR,
		ST_DIVU,
		ST_AXIS,
		ST_DIV1,
		ST_DIV2,
		ST_LERP,
		ST_LERP_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		LP_IDLE,
		LP_LO,
		LP_HI,
		LP_ACC,
		LP_FIN
	} lerp_phase_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ===== design/crp_key_store.sv =====
// Key memory: one write port and one registered read port.
module crp_key_store
	import crp_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [$clog2(MAX_KEYS)-1:0] wr_addr,
	input  key_t wr_data,
	input  logic [$clog2(MAX_KEYS)-1:0] rd_addr,
	output key_t rd_data
);

	key_t mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/crp_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module crp_divider
	import crp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic done,
	output logic [DIV_NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] trial_sub;
	logic ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

// ===== design/crp_lerp.sv =====
// Fixed-point lerp with rounding and saturation on one shared 17 x 32 multiplier.
module crp_lerp
	import crp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	input  logic signed [31:0] u,
	output logic done,
	output logic signed [31:0] res
);

	localparam int LO_W = 16;
	localparam int DIFF_W = 33;
	localparam int PROD_W = DIFF_W - LO_W + 32;
	localparam int ACC_W = DIFF_W + 32;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

	lerp_phase_t phase_q, phase_d;
	logic done_q;
	logic signed [31:0] a_q;
	logic signed [31:0] u_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [DIFF_W-LO_W-1:0] mop;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] lo_q;
	logic signed [PROD_W-1:0] hi_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [63:0] sum;
	logic signed [31:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LP_IDLE;
			done_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q <= (phase_q == LP_FIN);
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			LP_IDLE: if (start) phase_d = LP_LO;
			LP_LO: phase_d = LP_HI;
			LP_HI: phase_d = LP_ACC;
			LP_ACC: phase_d = LP_FIN;
			LP_FIN: phase_d = LP_IDLE;
			default: phase_d = LP_IDLE;
		endcase
	end

	assign mop = (phase_q == LP_LO) ? $signed({1'b0, diff_q[LO_W-1:0]})
		: $signed(diff_q[DIFF_W-1:LO_W]);
	assign prod = mop * u_q;
	assign acc_sh = acc_q >>> FRAC_BITS;
	assign sum = 64'(a_q) + acc_sh[63:0];

	always_ff @(posedge clk) begin
		if (start && phase_q == LP_IDLE) begin
			a_q <= a;
			u_q <= u;
			diff_q <= DIFF_W'(b) - DIFF_W'(a);
		end
		case (phase_q)
			LP_LO: lo_q <= prod;
			LP_HI: hi_q <= prod;
			LP_ACC: acc_q <= (ACC_W'(hi_q) <<< LO_W) + ACC_W'(lo_q) + HALF;
			LP_FIN: res_q <= sat32(sum);
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== design/catmull_rom_path_3d_top.sv =====
// Catmull-Rom 3D path evaluator: key store, command sequencer and shared arithmetic.
//
// One input word carries a command (insert key, clear keys, evaluate at a time) with
// the key fields; every accepted word yields exactly one output word holding the
// evaluated position, the key count after the command and a status code.
// Both channels move a word at a clock edge where valid is high and stall is low.
// The block takes one word at a time: in_stall stays high from acceptance until the
// result is placed in the output register. A finished result may sit in that
// register while the next word is already accepted.
// Insert scans the store from the top and moves each key with a later time one place
// up (a read and a check per key) before it writes the new key.
// Evaluation with N >= 3 keys runs a search that reads the keys one by one, loads the
// four keys around the segment, runs one division on the one-bit-per-cycle divider,
// then per axis forms the control points with a reciprocal multiply by one third and
// runs six lerps on the shared multiplier with three shifts. Two keys need a single
// lerp per axis; zero or one key skip the arithmetic.
// Reset empties the store at once; the key memory itself is not cleared.
// When out_stall is high the result waits in the output register and the block
// finishes its current word but accepts no further word until the register is free.
module catmull_rom_path_3d_top
	import crp_pkg::*;
#(
	parameter int MAX_KEYS = DEF_MAX_KEYS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] command,
	input  logic signed [31:0] time_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic hold_velocity,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [6:0] key_count,
	output logic [1:0] status
);

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam logic [DIV_NUM_W-1:0] U_MAX = DIV_NUM_W'(32'h7fffffff);
	localparam logic [63:0] THIRD_RECIP = 64'(32'haaaaaaab);

	function automatic logic [32:0] mag33(input logic signed [32:0] x);
		logic [32:0] r;
		r = x[32] ? 33'(-x) : 33'(x);
		return r;
	endfunction

	state_t state_q, state_d;
	logic [CW-1:0] n_q;
	logic out_valid_q;

	logic signed [31:0] t_q;
	key_t new_key_q;
	logic [1:0] status_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] seg_q;
	logic [1:0] ldj_q;
	key_t ent_q [4];
	logic neg_q;
	logic signed [31:0] u_q;
	logic [1:0] ax_q;
	logic signed [31:0] pt_q [4];
	logic [3:0] step_q;
	logic signed [31:0] res_q [3];

	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic [6:0] key_count_q;
	logic [1:0] out_status_q;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	key_t wr_data;
	logic [AW-1:0] rd_addr;
	key_t rd_data;

	logic div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	logic lerp_start;
	logic lerp_done;
	logic signed [31:0] lerp_res;

	logic t_lt_rd;
	logic [CW:0] ld_pos;
	logic ld_ok;
	logic first_seg, last_seg;
	logic signed [31:0] c0, c3, pm, pp, v0, v1;
	logic signed [32:0] tan1, tan2, tdiff, dur;
	logic signed [32:0] d3_op;
	logic [31:0] d3_mag;
	logic [63:0] d3_prod;
	logic [33:0] qmag;
	logic signed [33:0] qs;
	logic [30:0] umag;
	logic signed [31:0] u_next;
	logic out_load;
	key_t in_key;

	crp_key_store #(.MAX_KEYS(MAX_KEYS)) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	crp_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quo(div_quo)
	);

	crp_lerp u_lerp (
		.clk(clk),
		.arst_n(arst_n),
		.start(lerp_start),
		.a(pt_q[0]),
		.b(pt_q[1]),
		.u(u_q),
		.done(lerp_done),
		.res(lerp_res)
	);

	assign in_key.tstamp = time_value;
	assign in_key.pos = {pos_z, pos_y, pos_x};
	assign in_key.vel = {vel_z, vel_y, vel_x};
	assign in_key.hold = hold_velocity;

	assign t_lt_rd = t_q < $signed(rd_data.tstamp);
	assign ld_pos = (CW + 1)'(seg_q) + (CW + 1)'(ldj_q);
	assign ld_ok = (ld_pos != '0) && (ld_pos <= (CW + 1)'(n_q));
	assign first_seg = (seg_q == '0);
	assign last_seg = ((CW + 1)'(seg_q) + (CW + 1)'(2)) >= (CW + 1)'(n_q);

	assign c0 = $signed(ent_q[1].pos[ax_q]);
	assign c3 = $signed(ent_q[2].pos[ax_q]);
	assign pm = $signed(ent_q[0].pos[ax_q]);
	assign pp = $signed(ent_q[3].pos[ax_q]);
	assign v0 = $signed(ent_q[1].vel[ax_q]);
	assign v1 = $signed(ent_q[2].vel[ax_q]);

	always_comb begin
		if (ent_q[1].hold) begin
			tan1 = 33'(v0);
		end else if (first_seg) begin
			tan1 = 33'(c3) - 33'(c0);
		end else begin
			tan1 = (33'(c3) - 33'(pm)) >>> 1;
		end
		if (ent_q[2].hold) begin
			tan2 = -33'(v1);
		end else if (last_seg) begin
			tan2 = 33'(c0) - 33'(c3);
		end else begin
			tan2 = (33'(c0) - 33'(pp)) >>> 1;
		end
	end

	// A tangent magnitude stays below 2^32, where the reciprocal gives an exact floor.
	assign d3_op = (state_q == ST_DIV2) ? tan2 : tan1;
	assign d3_mag = 32'(mag33(d3_op));
	assign d3_prod = 64'(d3_mag) * THIRD_RECIP;
	assign qmag = {3'b000, d3_prod[63:33]};
	assign qs = d3_op[32] ? -$signed(qmag) : $signed(qmag);

	assign tdiff = 33'(t_q) - 33'($signed(ent_q[1].tstamp));
	assign dur = 33'($signed(ent_q[2].tstamp)) - 33'($signed(ent_q[1].tstamp));
	assign umag = (div_quo > U_MAX) ? 31'h7fffffff : div_quo[30:0];
	assign u_next = neg_q ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_valid && command == CMD_CLEAR) begin
				n_q <= '0;
			end else if (state_q == ST_INS_WR) begin
				n_q <= n_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_data;
		rd_addr = '0;
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		lerp_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (command)
						CMD_INSERT: state_d = (n_q >= CW'(MAX_KEYS)) ? ST_OUT : ST_INS_RD;
						CMD_EVAL: begin
							if (n_q == '0) begin
								state_d = ST_OUT;
							end else if (n_q == CW'(1)) begin
								state_d = ST_ONE;
							end else begin
								state_d = ST_SRCH_RD;
							end
						end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_INS_RD: begin
				if (idx_q == '0) begin
					state_d = ST_INS_WR;
				end else begin
					rd_addr = AW'(idx_q - CW'(1));
					state_d = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (t_lt_rd) begin
					wr_en = 1'b1;
					state_d = ST_INS_RD;
				end else begin
					state_d = ST_INS_WR;
				end
			end
			ST_INS_WR: begin
				wr_en = 1'b1;
				wr_data = new_key_q;
				state_d = ST_OUT;
			end
			ST_ONE: state_d = ST_OUT;
			ST_SRCH_RD: begin
				rd_addr = idx_q[AW-1:0];
				state_d = ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				if (t_lt_rd || idx_q == n_q - CW'(1)) begin
					state_d = ST_LD_RD;
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_LD_RD: begin
				rd_addr = ld_ok ? AW'(ld_pos - (CW + 1)'(1)) : '0;
				state_d = ST_LD_CAP;
			end
			ST_LD_CAP: state_d = (ldj_q == 2'd3) ? ST_DUR : ST_LD_RD;
			ST_DUR: begin
				if (dur <= 0) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					div_num = {mag33(tdiff), FRAC_BITS'(0)};
					div_den = dur;
					state_d = ST_DIVU;
				end
			end
			ST_DIVU: if (div_done) state_d = ST_AXIS;
			ST_AXIS: begin
				if (n_q == CW'(2)) begin
					state_d = ST_LERP;
				end else begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: state_d = ST_DIV2;
			ST_DIV2: state_d = ST_LERP;
			ST_LERP: begin
				if (LERP_SEQ[step_q]) begin
					lerp_start = 1'b1;
					state_d = ST_LERP_WAIT;
				end
			end
			ST_LERP_WAIT: begin
				if (lerp_done) begin
					if (step_q == 4'(LERP_LAST)) begin
						state_d = (ax_q == 2'd2) ? ST_OUT : ST_AXIS;
					end else begin
						state_d = ST_LERP;
					end
				end
			end
			ST_OUT: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					t_q <= time_value;
					new_key_q <= in_key;
					res_q[0] <= '0;
					res_q[1] <= '0;
					res_q[2] <= '0;
					status_q <= STAT_OK;
					idx_q <= (command == CMD_EVAL) ? CW'(1) : n_q;
					if (command == CMD_INSERT && n_q >= CW'(MAX_KEYS)) begin
						status_q <= STAT_FULL;
					end
				end
			end
			ST_INS_CHK: if (t_lt_rd) idx_q <= idx_q - CW'(1);
			ST_ONE: begin
				res_q[0] <= $signed(rd_data.pos[0]);
				res_q[1] <= $signed(rd_data.pos[1]);
				res_q[2] <= $signed(rd_data.pos[2]);
			end
			ST_SRCH_CHK: begin
				ldj_q <= '0;
				if (t_lt_rd) begin
					seg_q <= idx_q - CW'(1);
				end else if (idx_q == n_q - CW'(1)) begin
					seg_q <= n_q - CW'(2);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_LD_CAP: begin
				ent_q[ldj_q] <= rd_data;
				ldj_q <= ldj_q + 2'd1;
			end
			ST_DUR: begin
				neg_q <= tdiff[32];
				if (dur <= 0) begin
					status_q <= STAT_ZERO_SEG;
					res_q[0] <= $signed(ent_q[1].pos[0]);
					res_q[1] <= $signed(ent_q[1].pos[1]);
					res_q[2] <= $signed(ent_q[1].pos[2]);
				end
			end
			ST_DIVU: begin
				if (div_done) begin
					u_q <= u_next;
					ax_q <= '0;
				end
			end
			ST_AXIS: begin
				pt_q[0] <= c0;
				if (n_q == CW'(2)) begin
					pt_q[1] <= c3;
					step_q <= 4'(LERP_LAST);
				end else begin
					pt_q[3] <= c3;
				end
			end
			ST_DIV1: pt_q[1] <= sat32(64'(34'(pt_q[0]) + qs));
			ST_DIV2: begin
				pt_q[2] <= sat32(64'(34'(pt_q[3]) + qs));
				step_q <= '0;
			end
			ST_LERP: begin
				if (!LERP_SEQ[step_q]) begin
					pt_q[0] <= pt_q[1];
					pt_q[1] <= pt_q[2];
					pt_q[2] <= pt_q[3];
					step_q <= step_q + 4'd1;
				end
			end
			ST_LERP_WAIT: begin
				if (lerp_done) begin
					if (step_q == 4'(LERP_LAST)) begin
						res_q[ax_q] <= lerp_res;
						ax_q <= ax_q + 2'd1;
					end else begin
						pt_q[0] <= pt_q[1];
						pt_q[1] <= pt_q[2];
						pt_q[2] <= pt_q[3];
						pt_q[3] <= lerp_res;
						step_q <= step_q + 4'd1;
					end
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_x_q <= res_q[0];
			out_y_q <= res_q[1];
			out_z_q <= res_q[2];
			key_count_q <= 7'(n_q);
			out_status_q <= status_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign key_count = key_count_q;
	assign status = out_status_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Catmull-Rom 3D path evaluator: queued stimulus, predictor, checker.
`timescale 1ns / 100ps

module tb_top
	import crp_pkg::*;
();

	typedef struct {
		logic [1:0] cmd;
		logic signed [31:0] t;
		logic signed [31:0] p [3];
		logic h;
		logic signed [31:0] v [3];
		int sidle;
		int ridle;
		bit hold_rx;
		bit drain;
	} key_cmd_t;

	typedef struct {
		logic signed [31:0] p [3];
		logic [6:0] kc;
		logic [1:0] st;
	} path_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic signed [31:0] time_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic hold_velocity = 1'b0;
	logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic [6:0] key_count;
	logic [1:0] status;

	catmull_rom_path_3d_top u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .time_value(time_value), .pos_x(pos_x), .pos_y(pos_y),
		.pos_z(pos_z), .hold_velocity(hold_velocity), .vel_x(vel_x), .vel_y(vel_y),
		.vel_z(vel_z), .out_valid(out_valid), .out_stall(out_stall), .out_x(out_x),
		.out_y(out_y), .out_z(out_z), .key_count(key_count), .status(status)
	);

	key_cmd_t pending_cmds [$];
	path_point_t expected_points [$];
	key_cmd_t cur;
	int errors = 0;
	int words_sent = 0;
	int words_seen = 0;
	int evals_sent = 0;
	int cur_ridle = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	bit gen_done = 0;

	// Predictor state: the sorted key store.
	longint key_t_s [64];
	longint key_p_s [3][64];
	longint key_v_s [3][64];
	bit key_h_s [64];
	int keys_n = 0;

	function automatic longint sat(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic longint blend(longint a, longint b, longint u);
		longint r;
		r = ((b - a) * u + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		return sat(a + r);
	endfunction

	function automatic longint bezier_pos(int ax, int seg, int n, longint u);
		longint c0, c3, t1, t2, c1, c2, a, b, c, d, e;
		c0 = key_p_s[ax][seg];
		c3 = key_p_s[ax][seg + 1];
		if (seg == 0) begin
			t1 = c3 - c0;
			t2 = (c0 - key_p_s[ax][2]) >>> 1;
		end else if (seg + 2 >= n) begin
			t1 = (c3 - key_p_s[ax][seg - 1]) >>> 1;
			t2 = c0 - c3;
		end else begin
			t1 = (c3 - key_p_s[ax][seg - 1]) >>> 1;
			t2 = (c0 - key_p_s[ax][seg + 2]) >>> 1;
		end
		if (key_h_s[seg]) t1 = key_v_s[ax][seg];
		if (key_h_s[seg + 1]) t2 = -key_v_s[ax][seg + 1];
		c1 = sat(c0 + t1 / 3);
		c2 = sat(c3 + t2 / 3);
		a = blend(c0, c1, u);
		b = blend(c1, c2, u);
		c = blend(c2, c3, u);
		d = blend(a, b, u);
		e = blend(b, c, u);
		return blend(d, e, u);
	endfunction

	task automatic predict_path(input key_cmd_t w, output path_point_t r);
		longint t, dur, u;
		int at, seg;
		r.p[0] = 0; r.p[1] = 0; r.p[2] = 0;
		r.st = STAT_OK;
		t = w.t;
		if (w.cmd == CMD_INSERT) begin
			if (keys_n >= 64) begin
				r.st = STAT_FULL;
			end else begin
				at = keys_n;
				for (int k = 0; k < keys_n; k++) begin
					if (t < key_t_s[k]) begin
						at = k;
						break;
					end
				end
				for (int k = keys_n; k > at; k--) begin
					key_t_s[k] = key_t_s[k - 1];
					key_h_s[k] = key_h_s[k - 1];
					for (int ax = 0; ax < 3; ax++) begin
						key_p_s[ax][k] = key_p_s[ax][k - 1];
						key_v_s[ax][k] = key_v_s[ax][k - 1];
					end
				end
				key_t_s[at] = t;
				key_h_s[at] = w.h;
				for (int ax = 0; ax < 3; ax++) begin
					key_p_s[ax][at] = w.p[ax];
					key_v_s[ax][at] = w.v[ax];
				end
				keys_n++;
			end
		end else if (w.cmd == CMD_CLEAR) begin
			keys_n = 0;
		end else if (w.cmd == CMD_EVAL && keys_n == 1) begin
			for (int ax = 0; ax < 3; ax++) r.p[ax] = 32'(key_p_s[ax][0]);
		end else if (w.cmd == CMD_EVAL && keys_n > 1) begin
			seg = keys_n - 2;
			if (keys_n >= 3) begin
				for (int k = 1; k < keys_n; k++) begin
					if (t < key_t_s[k]) begin
						seg = k - 1;
						break;
					end
				end
			end
			dur = key_t_s[seg + 1] - key_t_s[seg];
			if (dur <= 0) begin
				r.st = STAT_ZERO_SEG;
				for (int ax = 0; ax < 3; ax++) r.p[ax] = 32'(key_p_s[ax][seg]);
			end else begin
				u = ((t - key_t_s[seg]) * (64'sd1 <<< FRAC_BITS)) / dur;
				if (u > 64'sd2147483647) u = 64'sd2147483647;
				if (u < -64'sd2147483647) u = -64'sd2147483647;
				for (int ax = 0; ax < 3; ax++) begin
					if (keys_n == 2)
						r.p[ax] = 32'(blend(key_p_s[ax][0], key_p_s[ax][1], u));
					else r.p[ax] = 32'(bezier_pos(ax, seg, keys_n, u));
				end
			end
		end
		r.kc = keys_n[6:0];
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
			2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(2000)) - 32'sd1000;
		endcase
	endfunction

	int cur_sidle = 0, cur_rpct = 0;

	task automatic add_word(input logic [1:0] cmd, input logic signed [31:0] t,
		input bit rnd_body, input bit hold);
		key_cmd_t w;
		w.cmd = cmd;
		w.t = t;
		w.h = hold;
		for (int ax = 0; ax < 3; ax++) begin
			w.p[ax] = rnd_body ? rand_val() : 32'sd0;
			w.v[ax] = rnd_body ? rand_val() : 32'sd0;
		end
		w.sidle = cur_sidle;
		w.ridle = cur_rpct;
		w.hold_rx = 0;
		w.drain = 0;
		pending_cmds = {pending_cmds, w};
	endtask

	task automatic set_phase(int count);
		case ((count / 200) % 4)
			0: begin cur_sidle = 0; cur_rpct = 0; end
			1: begin cur_sidle = 45; cur_rpct = 0; end
			2: begin cur_sidle = 0; cur_rpct = 45; end
			default: begin cur_sidle = 6; cur_rpct = 6; end
		endcase
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		int nk, ne, tb_base, tb_span;
		logic signed [31:0] kt;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty store, one key, two keys, ties, extremes, held velocity, an unknown command.
		add_word(CMD_EVAL, 32'sd0, 1, 0);
		add_word(CMD_INSERT, 32'sd65536, 1, 0);
		add_word(CMD_EVAL, 32'sd0, 1, 0);
		add_word(CMD_INSERT, 32'sd65536, 1, 1);
		add_word(CMD_EVAL, 32'sd65536, 0, 0);
		add_word(CMD_CLEAR, 32'sd0, 1, 0);
		add_word(CMD_INSERT, 32'sh80000000, 1, 0);
		add_word(CMD_INSERT, 32'sh7fffffff, 1, 0);
		add_word(CMD_EVAL, 32'sd0, 0, 0);
		add_word(CMD_EVAL, 32'sh7fffffff, 0, 0);
		add_word(CMD_INSERT, 32'sd0, 1, 1);
		add_word(CMD_INSERT, 32'sd131072, 1, 1);
		add_word(CMD_EVAL, 32'sh80000000, 0, 0);
		add_word(CMD_EVAL, 32'sd65536, 0, 0);
		add_word(CMD_EVAL, 32'sh7fffffff, 0, 0);
		add_word(CMD_EVAL, 32'sd200000, 0, 0);
		add_word(2'd3, 32'sd5, 1, 1);
		add_word(CMD_CLEAR, 32'sd0, 0, 0);
		for (int i = 0; i < 4; i++) add_word(CMD_INSERT, i * 65536, 1, i[0]);
		add_word(CMD_EVAL, 32'sd300000, 0, 0);
		add_word(CMD_EVAL, -32'sd100000, 0, 0);

		// Random part: well-formed key sets followed by queries, with noise mixed in.
		while (pending_cmds.size() < 1550) begin
			set_phase(pending_cmds.size());
			if (pending_cmds.size() % 700 < 30 && $urandom_range(3) == 0) begin
				nk = 66;
				ne = 4;
			end else begin
				nk = $urandom_range(2, 9);
				ne = $urandom_range(2, 6);
			end
			tb_base = $signed($urandom_range(65536 * 200)) - 65536 * 100;
			tb_span = $urandom_range(3) == 0 ? 8 : 65536 * $urandom_range(1, 20);
			add_word(CMD_CLEAR, $urandom, 1, 1'($urandom_range(1)));
			if ($urandom_range(19) == 0) pending_cmds[$].drain = 1;
			for (int i = 0; i < nk; i++) begin
				case ($urandom_range(3))
					0: kt = $urandom;
					1: kt = tb_base + 65536 * $urandom_range(4);
					default: kt = tb_base + $urandom_range(tb_span);
				endcase
				add_word(CMD_INSERT, kt, 1, $urandom_range(3) == 0);
				if ($urandom_range(15) == 0)
					add_word(2'($urandom_range(3)), $urandom, 1, 1'($urandom_range(1)));
			end
			for (int i = 0; i < ne; i++) begin
				case ($urandom_range(4))
					0: kt = $urandom;
					1: kt = tb_base - $urandom_range(tb_span);
					default: kt = tb_base + $urandom_range(2 * tb_span);
				endcase
				add_word(CMD_EVAL, kt, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			if ($urandom_range(29) == 0) pending_cmds[$].hold_rx = 1;
		end
		pending_cmds[pending_cmds.size() / 3].hold_rx = 1;
		pending_cmds[pending_cmds.size() / 2].drain = 1;
		gen_done = 1;

		wait (pending_cmds.size() == 0);
		while (in_valid || expected_points.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (expected_points.size() != 0) begin
			$display("%0d results never arrived", expected_points.size());
			errors++;
		end
		$display("Covered %0d words (%0d queries) and %0d results across four idle mixes.",
			words_sent, evals_sent, words_seen);
		if (errors == 0) begin
			$display("catmull_rom_path_3d_top regression: pass");
		end else begin
			$display("catmull_rom_path_3d_top regression: fail");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("catmull_rom_path_3d_top regression: fail");
		$finish;
	end

	always @(posedge clk) begin
		path_point_t r;
		if (arst_n && gen_done) begin
			if (in_valid && !in_stall) begin
				predict_path(cur, r);
				expected_points = {expected_points, r};
				words_sent++;
				if (cur.cmd == CMD_EVAL) evals_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].sidle
					&& (!pending_cmds[0].drain || expected_points.size() == 0)) begin
					cur = pending_cmds.pop_front();
					cur_ridle = cur.ridle;
					if (cur.hold_rx) hold_req = 1;
					in_valid <= 1'b1;
					command <= cur.cmd;
					time_value <= cur.t;
					pos_x <= cur.p[0];
					pos_y <= cur.p[1];
					pos_z <= cur.p[2];
					hold_velocity <= cur.h;
					vel_x <= cur.v[0];
					vel_y <= cur.v[1];
					vel_z <= cur.v[2];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		path_point_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (expected_points.size() == 0) begin
					errors++;
					if (errors <= 10) $display("Unexpected result word at %0t", $realtime);
				end else begin
					e = expected_points.pop_front();
					if (out_x !== e.p[0] || out_y !== e.p[1] || out_z !== e.p[2]
						|| key_count !== e.kc || status !== e.st) begin
						errors++;
						if (errors <= 10)
							$display(
								"Word %0d exp %0d %0d %0d/%0d/%0d got %0d %0d %0d/%0d/%0d",
								words_seen, e.p[0], e.p[1], e.p[2], e.kc, e.st,
								out_x, out_y, out_z, key_count, status);
					end
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 3000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < cur_ridle);
			end
		end
	end

endmodule

// ===== sim.f =====
design/crp_pkg.sv
design/crp_key_store.sv
design/crp_divider.sv
design/crp_lerp.sv
design/catmull_rom_path_3d_top.sv
tb/sv/tb_top.sv
